[hw/rtl/tss_pkg.sv]
// Shared types and constants of the TDMA slot sync scheduler.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int unsigned Slots    = 8;
  localparam int unsigned SlotIdxW = $clog2(Slots);
  localparam int unsigned SlotPtrW = 4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SYNC  = 2'd1,
    KIND_EVENT = 2'd2,
    KIND_REPLY = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot_index;
    logic [7:0]  slot_phase;
    logic [7:0]  slot_period;
    logic [31:0] slot_offset_ns;
    logic [31:0] sync_cycle;
    logic [63:0] time_a;
    logic [63:0] time_b;
    logic [63:0] time_c;
    logic [63:0] arrival_time;
    logic [63:0] local_time;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  slot_count;
    logic [15:0] init_cycles_limit;
    logic [15:0] calib_cycles_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_SLOT_COUNT  = 2'd0,
    CFG_INIT_LIMIT  = 2'd1,
    CFG_CALIB_LIMIT = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_e;

endpackage
`default_nettype wire

[hw/rtl/tss_front.sv]
// Front end: takes input beats, classifies the kind, holds a two-entry command queue.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tss_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push,
  output logic           full,
  input  wire [1:0]      kind_i,
  input  wire [2:0]      slot_index_i,
  input  wire [7:0]      slot_phase_i,
  input  wire [7:0]      slot_period_i,
  input  wire [31:0]     slot_offset_ns_i,
  input  wire [31:0]     sync_cycle_i,
  input  wire [63:0]     time_a_i,
  input  wire [63:0]     time_b_i,
  input  wire [63:0]     time_c_i,
  input  wire [63:0]     arrival_time_i,
  input  wire [63:0]     local_time_i,
  output logic           cmd_valid_o,
  output tss_pkg::cmd_t  cmd_o,
  input  wire            cmd_pop_i
);
  import tss_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.kind           = kind_e'(kind_i);
    cmd_in.slot_index     = slot_index_i;
    cmd_in.slot_phase     = slot_phase_i;
    cmd_in.slot_period    = slot_period_i;
    cmd_in.slot_offset_ns = slot_offset_ns_i;
    cmd_in.sync_cycle     = sync_cycle_i;
    cmd_in.time_a         = time_a_i;
    cmd_in.time_b         = time_b_i;
    cmd_in.time_c         = time_c_i;
    cmd_in.arrival_time   = arrival_time_i;
    cmd_in.local_time     = local_time_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tss_div.sv]
// Iterative restoring divider, one quotient bit per cycle, 64-bit dividend, 16-bit divisor.
// Depends on tss_pkg (import only).
`timescale 1ns / 1ps
`default_nettype none
module tss_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] dividend_i,
  input  wire  [15:0] divisor_i,
  input  wire  [6:0]  steps_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [15:0] rem_o
);
  import tss_pkg::*;

  logic [63:0] dd_q;
  logic [15:0] dv_q, r_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] trial;
  logic        qbit;

  assign trial  = {r_q, dd_q[63]};
  assign qbit   = (trial >= {1'b0, dv_q});
  assign done_o = done_q;
  assign quot_o = dd_q;
  assign rem_o  = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dd_q   <= '0;
      dv_q   <= '0;
      r_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dd_q   <= dividend_i;
        dv_q   <= divisor_i;
        r_q    <= '0;
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dd_q  <= {dd_q[62:0], qbit};
        r_q   <= qbit ? 16'(trial - {1'b0, dv_q}) : trial[15:0];
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tss_back.sv]
// Back end: executes commands, holds slot table and timing state, drives the result register.
// Depends on tss_pkg and tss_div.
`timescale 1ns / 1ps
`default_nettype none
module tss_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  tss_pkg::cfg_t  cfg_i,
  input  wire            cmd_valid_i,
  input  tss_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  wire            pop,
  output logic           set_time_valid_o,
  output logic [63:0]    new_local_time_o,
  output logic           next_slot_valid_o,
  output logic [63:0]    next_slot_time_o,
  output logic           request_calibration_o,
  output logic [1:0]     phase_o
);
  import tss_pkg::*;

  localparam logic [1:0] PhInit  = 2'd0;
  localparam logic [1:0] PhCalib = 2'd1;
  localparam logic [1:0] PhRun   = 2'd2;
  localparam logic [SlotPtrW-1:0] SlotsLim = SlotPtrW'(Slots);

  typedef enum logic [3:0] {
    S_IDLE, S_SYNC, S_REP, S_MUL_LO, S_MUL_HI, S_ADD, S_DIV_WAIT,
    S_SEARCH, S_MOD_WAIT, S_DONE
  } state_e;

  state_e state_q;

  logic [7:0]  phase_tab_q  [Slots];
  logic [7:0]  period_tab_q [Slots];
  logic [31:0] offset_tab_q [Slots];

  cmd_t          cmd_q;
  logic [31:0]   cycle_q;
  logic [SlotPtrW-1:0] sp_q;
  logic [63:0]   base_q, td_q, off_q, tmp_q, acc_q;
  logic [31:0]   hi_q;
  logic [15:0]   init_cnt_q, calib_cnt_q;
  logic [1:0]    phase_q;
  logic          await_q;
  logic          set_v_q, nx_v_q, req_q;
  logic [63:0]   new_t_q, nx_t_q;
  logic          out_valid_q, out_valid_d;

  logic          div_start_q;
  logic [63:0]   div_dd_q;
  logic [15:0]   div_dv_q;
  logic [6:0]    div_steps_q;
  logic          div_done;
  logic [63:0]   div_quot;
  logic [15:0]   div_rem;

  logic [SlotPtrW-1:0] lim;
  logic [SlotIdxW-1:0] sp_idx;
  logic [15:0]   init_inc, calib_inc, n_minus1;
  logic [1:0]    sync_phase_d;
  logic [63:0]   sync_off_d;

  assign lim       = (cfg_i.slot_count > SlotsLim) ? SlotsLim : cfg_i.slot_count;
  assign sp_idx    = sp_q[SlotIdxW-1:0];
  assign init_inc  = (init_cnt_q == 16'hFFFF) ? init_cnt_q : init_cnt_q + 16'd1;
  assign calib_inc = (calib_cnt_q == 16'hFFFF) ? calib_cnt_q : calib_cnt_q + 16'd1;
  assign n_minus1  = calib_cnt_q - 16'd1;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign empty     = !out_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) out_valid_d = 1'b0;
    if (state_q == S_DONE && (!out_valid_q || pop)) out_valid_d = 1'b1;
  end

  always_comb begin
    sync_phase_d = phase_q;
    sync_off_d   = cmd_i.time_a + td_q - cmd_i.arrival_time;
    if (phase_q == PhInit) begin
      sync_off_d = '0;
      if (init_inc >= cfg_i.init_cycles_limit) sync_phase_d = PhCalib;
    end
  end

  tss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dd_q),
    .divisor_i  (div_dv_q),
    .steps_i    (div_steps_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.kind == KIND_WRITE) begin
      phase_tab_q[cmd_i.slot_index[SlotIdxW-1:0]]  <= cmd_i.slot_phase;
      period_tab_q[cmd_i.slot_index[SlotIdxW-1:0]] <= cmd_i.slot_period;
      offset_tab_q[cmd_i.slot_index[SlotIdxW-1:0]] <= cmd_i.slot_offset_ns;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      cycle_q     <= '0;
      sp_q        <= '0;
      base_q      <= '0;
      td_q        <= '0;
      off_q       <= '0;
      tmp_q       <= '0;
      acc_q       <= '0;
      hi_q        <= '0;
      init_cnt_q  <= '0;
      calib_cnt_q <= '0;
      phase_q     <= PhInit;
      await_q     <= 1'b0;
      set_v_q     <= 1'b0;
      nx_v_q      <= 1'b0;
      req_q       <= 1'b0;
      new_t_q     <= '0;
      nx_t_q      <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      div_dd_q    <= '0;
      div_dv_q    <= '0;
      div_steps_q <= '0;
      set_time_valid_o      <= 1'b0;
      new_local_time_o      <= '0;
      next_slot_valid_o     <= 1'b0;
      next_slot_time_o      <= '0;
      request_calibration_o <= 1'b0;
      phase_o               <= PhInit;
    end else begin
      div_start_q <= 1'b0;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            set_v_q <= 1'b0;
            nx_v_q  <= 1'b0;
            req_q   <= 1'b0;
            new_t_q <= '0;
            nx_t_q  <= '0;
            unique case (cmd_i.kind)
              KIND_WRITE: state_q <= S_DONE;
              KIND_SYNC: begin
                cycle_q <= cmd_i.sync_cycle;
                base_q  <= cmd_i.time_b;
                sp_q    <= '0;
                off_q   <= sync_off_d;
                tmp_q   <= cmd_i.local_time - cmd_i.arrival_time;
                if (phase_q == PhInit) init_cnt_q <= init_inc;
                phase_q <= sync_phase_d;
                if (sync_phase_d == PhCalib && !await_q) begin
                  await_q <= 1'b1;
                  req_q   <= 1'b1;
                end
                set_v_q <= 1'b1;
                nx_v_q  <= 1'b1;
                state_q <= S_SYNC;
              end
              KIND_EVENT: begin
                if (sp_q != '1) sp_q <= sp_q + 1'b1;
                nx_v_q  <= 1'b1;
                state_q <= S_SEARCH;
              end
              default: begin
                calib_cnt_q <= calib_inc;
                await_q     <= 1'b0;
                tmp_q       <= cmd_i.arrival_time - cmd_i.time_a;
                state_q     <= (phase_q == PhCalib) ? S_REP : S_DONE;
              end
            endcase
          end
        end
        S_SYNC: begin
          new_t_q <= cmd_q.local_time + off_q + tmp_q;
          state_q <= S_SEARCH;
        end
        S_REP: begin
          // halve the round-trip sample
          acc_q   <= (tmp_q - (cmd_q.time_c - cmd_q.time_b)) >> 1;
          state_q <= S_MUL_LO;
        end
        S_MUL_LO: begin
          tmp_q   <= 64'(td_q[31:0] * n_minus1);
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          hi_q    <= 32'(td_q[63:32] * n_minus1);
          state_q <= S_ADD;
        end
        S_ADD: begin
          div_dd_q    <= tmp_q + {hi_q, 32'd0} + acc_q;
          div_dv_q    <= calib_cnt_q;
          div_steps_q <= 7'd64;
          div_start_q <= 1'b1;
          state_q     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            td_q <= div_quot;
            if (calib_cnt_q >= cfg_i.calib_cycles_limit) phase_q <= PhRun;
            state_q <= S_DONE;
          end
        end
        S_SEARCH: begin
          if (sp_q >= lim) begin
            sp_q    <= '0;
            nx_t_q  <= '0;
            state_q <= S_DONE;
          end else if (period_tab_q[sp_idx] == 8'd1) begin
            nx_t_q  <= base_q + {32'd0, offset_tab_q[sp_idx]};
            state_q <= S_DONE;
          end else if (period_tab_q[sp_idx] == 8'd0) begin
            sp_q <= sp_q + 1'b1;
          end else begin
            // (cycle + 1) mod period: 32 steps on the upper half
            div_dd_q    <= {cycle_q + 32'd1, 32'd0};
            div_dv_q    <= {8'd0, period_tab_q[sp_idx]};
            div_steps_q <= 7'd32;
            div_start_q <= 1'b1;
            state_q     <= S_MOD_WAIT;
          end
        end
        S_MOD_WAIT: begin
          if (div_done) begin
            if (div_rem[7:0] == phase_tab_q[sp_idx]) begin
              nx_t_q  <= base_q + {32'd0, offset_tab_q[sp_idx]};
              state_q <= S_DONE;
            end else begin
              sp_q    <= sp_q + 1'b1;
              state_q <= S_SEARCH;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || pop) begin
            set_time_valid_o      <= set_v_q;
            new_local_time_o      <= new_t_q;
            next_slot_valid_o     <= nx_v_q;
            next_slot_time_o      <= nx_t_q;
            request_calibration_o <= req_q;
            phase_o               <= phase_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (sp_q <= SlotsLim))
    else $error("slot pointer out of range while idle");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("phase holds an unused code");

  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRun) |=> (phase_q == PhRun))
    else $error("left running phase");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT || state_q == S_MOD_WAIT))
    else $error("divider finished with no waiting state");

endmodule
`default_nettype wire

[hw/rtl/tdma_slot_sync_scheduler.sv]
// TDMA slave timing engine: front command queue, back executor, configuration registers.
// Slot write and reply outside calibration go straight to done; sync runs its sync state
// then the slot search, slot event the search alone, testing period above 1 on the divider.
// Calibration reply runs reply, multiply, add, then the 64-step divider in tss_div. One item
// runs at a time; an unpopped result holds the back end, the two-entry front queue accepts on.
// Reset (async, active low) clears control and timing state; slot table stays undefined.
`timescale 1ns / 1ps
`default_nettype none
module tdma_slot_sync_scheduler (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         push,
  output logic        full,
  input  wire  [1:0]  kind_i,
  input  wire  [2:0]  slot_index_i,
  input  wire  [7:0]  slot_phase_i,
  input  wire  [7:0]  slot_period_i,
  input  wire  [31:0] slot_offset_ns_i,
  input  wire  [31:0] sync_cycle_i,
  input  wire  [63:0] time_a_i,
  input  wire  [63:0] time_b_i,
  input  wire  [63:0] time_c_i,
  input  wire  [63:0] arrival_time_i,
  input  wire  [63:0] local_time_i,
  output logic        empty,
  input  wire         pop,
  output logic        set_time_valid_o,
  output logic [63:0] new_local_time_o,
  output logic        next_slot_valid_o,
  output logic [63:0] next_slot_time_o,
  output logic        request_calibration_o,
  output logic [1:0]  phase_o
);
  import tss_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_count         <= 4'd2;
      cfg_q.init_cycles_limit  <= 16'd16;
      cfg_q.calib_cycles_limit <= 16'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SLOT_COUNT:  cfg_q.slot_count         <= cfg_data_i[3:0];
        CFG_INIT_LIMIT:  cfg_q.init_cycles_limit  <= cfg_data_i;
        CFG_CALIB_LIMIT: cfg_q.calib_cycles_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tss_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .slot_index_i     (slot_index_i),
    .slot_phase_i     (slot_phase_i),
    .slot_period_i    (slot_period_i),
    .slot_offset_ns_i (slot_offset_ns_i),
    .sync_cycle_i     (sync_cycle_i),
    .time_a_i         (time_a_i),
    .time_b_i         (time_b_i),
    .time_c_i         (time_c_i),
    .arrival_time_i   (arrival_time_i),
    .local_time_i     (local_time_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  tss_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .cmd_valid_i           (cmd_valid),
    .cmd_i                 (cmd),
    .cmd_pop_o             (cmd_pop),
    .empty                 (empty),
    .pop                   (pop),
    .set_time_valid_o      (set_time_valid_o),
    .new_local_time_o      (new_local_time_o),
    .next_slot_valid_o     (next_slot_valid_o),
    .next_slot_time_o      (next_slot_time_o),
    .request_calibration_o (request_calibration_o),
    .phase_o               (phase_o)
  );

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for tdma_slot_sync_scheduler: directed and random items, scoreboard prediction.
// Depends on tss_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb;
  import tss_pkg::*;

  typedef enum bit [1:0] {PH_INIT = 2'd0, PH_CALIB = 2'd1, PH_RUN = 2'd2} sched_phase_e;

  typedef struct {
    bit        set_v;
    bit [63:0] new_t;
    bit        nx_v;
    bit [63:0] nx_t;
    bit        req;
    bit [1:0]  ph;
  } sched_out_t;

  class tss_scoreboard;
    bit [7:0]     phase_tab [8];
    bit [7:0]     period_tab [8];
    bit [31:0]    offset_tab [8];
    bit [31:0]    cyc;
    bit [3:0]     ptr;
    bit [63:0]    base_t;
    bit [63:0]    delay;
    bit [63:0]    offs;
    bit [15:0]    init_cnt;
    bit [15:0]    calib_cnt;
    sched_phase_e ph;
    bit           awaiting;
    bit [3:0]     slot_cnt = 4'd2;
    bit [15:0]    init_lim = 16'd16;
    bit [15:0]    calib_lim = 16'd16;
    sched_out_t   expected_q [$];
    int           fails;

    function void set_reg(cfg_idx_e idx, bit [15:0] val);
      case (idx)
        CFG_SLOT_COUNT: slot_cnt = val[3:0];
        CFG_INIT_LIMIT: init_lim = val;
        CFG_CALIB_LIMIT: calib_lim = val;
        default: ;
      endcase
    endfunction

    function bit [63:0] find_slot();
      int        lim;
      bit [31:0] nxt;
      lim = (slot_cnt > 8) ? 8 : slot_cnt;
      nxt = cyc + 32'd1;
      for (int i = ptr; i < lim; i++) begin
        if (period_tab[i] == 8'd1 ||
            (period_tab[i] != 8'd0 && phase_tab[i] == nxt % period_tab[i])) begin
          ptr = i[3:0];
          return base_t + {32'd0, offset_tab[i]};
        end
      end
      ptr = 4'd0;
      return 64'd0;
    endfunction

    function void note_item(cmd_t c);
      sched_out_t e;
      bit [63:0]  n;
      bit [63:0]  sample;
      e = '{default: 0};
      case (c.kind)
        KIND_WRITE: begin
          phase_tab[c.slot_index] = c.slot_phase;
          period_tab[c.slot_index] = c.slot_period;
          offset_tab[c.slot_index] = c.slot_offset_ns;
        end
        KIND_SYNC: begin
          cyc = c.sync_cycle;
          base_t = c.time_b;
          ptr = 4'd0;
          offs = c.time_a + delay - c.arrival_time;
          if (ph == PH_INIT) begin
            offs = 64'd0;
            if (init_cnt != 16'hffff) init_cnt++;
            if (init_cnt >= init_lim) ph = PH_CALIB;
          end
          e.set_v = 1'b1;
          e.new_t = c.local_time + offs + (c.local_time - c.arrival_time);
          e.nx_v = 1'b1;
          e.nx_t = find_slot();
          if (ph == PH_CALIB && !awaiting) begin
            awaiting = 1'b1;
            e.req = 1'b1;
          end
        end
        KIND_EVENT: begin
          if (ptr != 4'd15) ptr++;
          e.nx_v = 1'b1;
          e.nx_t = find_slot();
        end
        default: begin
          if (calib_cnt != 16'hffff) calib_cnt++;
          awaiting = 1'b0;
          if (ph == PH_CALIB) begin
            n = {48'd0, calib_cnt};
            sample = ((c.arrival_time - c.time_a) - (c.time_c - c.time_b)) >> 1;
            delay = ((n - 64'd1) * delay + sample) / n;
            if (calib_cnt >= calib_lim) ph = PH_RUN;
          end
        end
      endcase
      e.ph = ph;
      expected_q.push_back(e);
    endfunction

    function void check_result(sched_out_t a);
      sched_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got next_slot_time %h", $time, a.nx_t);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (a.set_v != e.set_v) begin
        $display("%0t: set_time_valid exp %0d act %0d", $time, e.set_v, a.set_v);
        fails++;
      end
      if (a.new_t != e.new_t) begin
        $display("%0t: new_local_time exp %h act %h", $time, e.new_t, a.new_t);
        fails++;
      end
      if (a.nx_v != e.nx_v) begin
        $display("%0t: next_slot_valid exp %0d act %0d", $time, e.nx_v, a.nx_v);
        fails++;
      end
      if (a.nx_t != e.nx_t) begin
        $display("%0t: next_slot_time exp %h act %h", $time, e.nx_t, a.nx_t);
        fails++;
      end
      if (a.req != e.req) begin
        $display("%0t: request_calibration exp %0d act %0d", $time, e.req, a.req);
        fails++;
      end
      if (a.ph != e.ph) begin
        $display("%0t: phase exp %0d act %0d", $time, e.ph, a.ph);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind_i = '0;
  logic [2:0]  slot_index_i = '0;
  logic [7:0]  slot_phase_i = '0;
  logic [7:0]  slot_period_i = '0;
  logic [31:0] slot_offset_ns_i = '0;
  logic [31:0] sync_cycle_i = '0;
  logic [63:0] time_a_i = '0;
  logic [63:0] time_b_i = '0;
  logic [63:0] time_c_i = '0;
  logic [63:0] arrival_time_i = '0;
  logic [63:0] local_time_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        set_time_valid_o;
  logic [63:0] new_local_time_o;
  logic        next_slot_valid_o;
  logic [63:0] next_slot_time_o;
  logic        request_calibration_o;
  logic [1:0]  phase_o;

  tss_scoreboard sb = new();
  int tx_gap_max;
  int rx_gap_max;
  int popped;
  bit stalled;

  tdma_slot_sync_scheduler dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic bit [63:0] rand_time();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'(~64'd0 - $urandom_range(0, 1000));
      default: return 64'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic cmd_t rand_item();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c.kind = (r < 15) ? KIND_WRITE : (r < 45) ? KIND_SYNC : (r < 80) ? KIND_EVENT : KIND_REPLY;
    c.slot_index = 3'($urandom);
    c.slot_phase = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.slot_period = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
    c.slot_offset_ns = $urandom;
    c.sync_cycle = ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : $urandom;
    c.time_a = rand_time();
    c.time_b = rand_time();
    c.time_c = rand_time();
    c.arrival_time = rand_time();
    c.local_time = rand_time();
    return c;
  endfunction

  task automatic send(cmd_t c);
    int gap;
    push <= 1'b1;
    kind_i <= c.kind;
    slot_index_i <= c.slot_index;
    slot_phase_i <= c.slot_phase;
    slot_period_i <= c.slot_period;
    slot_offset_ns_i <= c.slot_offset_ns;
    sync_cycle_i <= c.sync_cycle;
    time_a_i <= c.time_a;
    time_b_i <= c.time_b;
    time_c_i <= c.time_c;
    arrival_time_i <= c.arrival_time;
    local_time_i <= c.local_time;
    do @(posedge clk_i); while (full);
    sb.note_item(c);
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // hold the input side until every beat has drained, then let the engine settle
  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_write(int idx, int phs, int per, bit [31:0] offs);
    cmd_t c;
    c = rand_item();
    c.kind = KIND_WRITE;
    c.slot_index = 3'(idx);
    c.slot_phase = 8'(phs);
    c.slot_period = 8'(per);
    c.slot_offset_ns = offs;
    send(c);
  endtask

  task automatic send_kind(kind_e k);
    cmd_t c;
    c = rand_item();
    c.kind = k;
    send(c);
  endtask

  // receiver: random pop gaps, one long hold-off to back the block up
  initial begin
    int w;
    sched_out_t a;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, rx_gap_max);
      if (popped == 150 && !stalled) begin
        stalled = 1'b1;
        w = 400;
      end
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      a.set_v = set_time_valid_o;
      a.new_t = new_local_time_o;
      a.nx_v = next_slot_valid_o;
      a.nx_t = next_slot_time_o;
      a.req = request_calibration_o;
      a.ph = phase_o;
      sb.check_result(a);
      popped++;
    end
  end

  initial begin
    cmd_t c;
    bit [15:0] slot_cfg [5] = '{16'd15, 16'd0, 16'd5, 16'd1, 16'd8};
    bit [15:0] init_cfg [5] = '{16'd65535, 16'd1, 16'd1, 16'd16, 16'd7};
    bit [15:0] calib_cfg [5] = '{16'd65535, 16'd65535, 16'd1, 16'd1, 16'd65535};
    tx_gap_max = 6;
    rx_gap_max = 6;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_SLOT_COUNT, 16'hfff8);
    write_reg(CFG_INIT_LIMIT, 16'd2);
    write_reg(CFG_CALIB_LIMIT, 16'd65535);
    write_reg(CFG_NONE, 16'hffff);
    // fill the whole table first so no search ever reads an unwritten entry
    send_write(0, 0, 1, 32'd0);
    send_write(1, 255, 255, 32'hffff_ffff);
    send_write(2, 0, 0, 32'd500);
    send_write(3, 1, 2, 32'd100);
    send_write(4, 0, 3, 32'd7);
    send_write(5, 255, 1, 32'h8000_0000);
    send_write(6, 2, 4, 32'd1);
    send_write(7, 0, 2, 32'd64);
    send_kind(KIND_REPLY);
    send_kind(KIND_SYNC);
    send_kind(KIND_EVENT);
    send_kind(KIND_EVENT);
    c = rand_item();
    c.kind = KIND_SYNC;
    c.sync_cycle = 32'hffff_ffff;
    send(c);
    send_kind(KIND_SYNC);
    c = rand_item();
    c.kind = KIND_REPLY;
    c.time_a = '1;
    c.time_b = '1;
    c.time_c = '1;
    c.arrival_time = '1;
    c.local_time = '1;
    send(c);
    c.time_a = '0;
    c.time_b = '0;
    c.time_c = '0;
    c.arrival_time = '0;
    c.local_time = '0;
    send(c);
    for (int i = 0; i < 6; i++) send_kind(KIND_EVENT);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_SLOT_COUNT, {12'($urandom), slot_cfg[p][3:0]});
      write_reg(CFG_INIT_LIMIT, init_cfg[p]);
      write_reg(CFG_CALIB_LIMIT, calib_cfg[p]);
      tx_gap_max = (p == 1) ? 0 : 6;
      rx_gap_max = (p == 3) ? 0 : 6;
      for (int i = 0; i < 28; i++) begin
        // mostly sync-led sequences: a sync, a few slot events, then maybe a reply
        if ($urandom_range(0, 3) != 0) begin
          send_kind(KIND_SYNC);
          repeat ($urandom_range(0, 4)) send_kind(KIND_EVENT);
          if ($urandom_range(0, 1) != 0) send_kind(KIND_REPLY);
        end else begin
          send(rand_item());
        end
      end
      drain();
    end

    if (sb.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tss_pkg.sv
hw/rtl/tss_front.sv
hw/rtl/tss_div.sv
hw/rtl/tss_back.sv
hw/rtl/tdma_slot_sync_scheduler.sv
test/tb.sv
